// ===== design/positional_list_store_defines.svh =====
// assertion macros for the positional list store
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLS_ASSERT_IMP(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error(msg_);

// next-cycle implication, disabled during reset
`define PLS_ASSERT_NXT(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== design/pls_pkg.sv =====
// shared types and constants of the positional list store
// no dependencies
package pls_pkg;

  localparam int DataW       = 32;
  localparam int PosW        = 6;
  localparam int CountW      = 6;
  localparam int DefCapacity = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } pls_status_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } pls_op_t;

endpackage

// ===== design/pls_cell.sv =====
// one storage cell of the positional list store row
// depends on pls_pkg
module pls_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic                               clk_i,
  input  pls_pkg::pls_op_t                   op_i,
  input  logic [IW-1:0]                      pos_i,
  input  logic signed [pls_pkg::DataW-1:0]   value_i,
  input  logic signed [pls_pkg::DataW-1:0]   left_i,
  input  logic signed [pls_pkg::DataW-1:0]   right_i,
  output logic signed [pls_pkg::DataW-1:0]   data_o,
  output logic signed [pls_pkg::DataW-1:0]   tap_o
);
  import pls_pkg::*;

  logic signed [DataW-1:0] data_d, data_q;
  logic                    at_pos, past_pos;

  assign at_pos   = (IW'(IDX) == pos_i);
  assign past_pos = (IW'(IDX) >  pos_i);

  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (past_pos) data_d = left_i;
      else if (at_pos) data_d = value_i;
    end else if (op_i.del) begin
      if (past_pos || at_pos) data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the addressed cell drives its value onto the removal bus
  assign tap_o  = at_pos ? data_q : '0;

endmodule

// ===== design/pls_ctrl.sv =====
// command decode, fill count and result registers of the positional list store
// depends on pls_pkg
module pls_ctrl #(
  parameter int CAPACITY = pls_pkg::DefCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                cmd_i,
  input  logic [pls_pkg::PosW-1:0]            position_i,
  input  logic signed [pls_pkg::DataW-1:0]    value_i,
  input  logic signed [pls_pkg::DataW-1:0]    removed_i,
  output pls_pkg::pls_op_t                    op_o,
  output logic [$clog2(CAPACITY)-1:0]         pos_o,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [pls_pkg::DataW-1:0]    item_value_o,
  output logic [pls_pkg::CountW-1:0]          count_o
);
  import pls_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0]          fc_d, fc_q;
  logic [CMPW-1:0]        pos_ext, fc_ext;
  logic                   full;
  pls_status_e            status_d;
  logic signed [DataW-1:0] value_d;
  pls_op_t                op;
  logic                   done_q;
  logic [1:0]             status_q;
  logic signed [DataW-1:0] value_q;
  logic [CountW-1:0]      count_q;

  assign pos_ext = CMPW'(position_i);
  assign fc_ext  = CMPW'(fc_q);
  assign full    = (fc_q == CW'(CAPACITY));

  always_comb begin
    status_d = ST_OK;
    value_d  = value_i;
    fc_d     = fc_q;
    op       = '0;
    if (cmd_i == CMD_INSERT) begin
      if (pos_ext > fc_ext) begin
        status_d = ST_BADPOS;
        value_d  = '0;
      end else if (full) begin
        status_d = ST_FULL;
        value_d  = '0;
      end else begin
        op.ins = accept_i;
        fc_d   = fc_q + CW'(1);
      end
    end else begin
      if (fc_q == '0) begin
        status_d = ST_EMPTY;
        value_d  = '0;
      end else if (pos_ext >= fc_ext) begin
        status_d = ST_BADPOS;
        value_d  = '0;
      end else begin
        op.del  = accept_i;
        value_d = removed_i;
        fc_d    = fc_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) fc_q <= fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_d;
      value_q  <= value_d;
      count_q  <= CountW'(fc_d);
    end
  end

  assign op_o         = op;
  assign pos_o        = pos_ext[IW-1:0];
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign item_value_o = value_q;
  assign count_o      = count_q;

endmodule

// ===== design/positional_list_store.sv =====
// Ordered store of up to CAPACITY signed 32-bit values held in a row of cells.
// An item is taken whenever start is high (busy stays low), one item per clock.
// Its result appears on the result ports, marked by done_o, in the cycle right
// after it was taken; the receiver cannot stall, so every result must be
// captured in that cycle. An insert or delete shifts the cells from the given
// position onward, at the clock edge that takes the item.
// Errors (empty, bad position, full) leave the contents and count unchanged.
// Depends on pls_pkg, pls_ctrl, pls_cell and positional_list_store_defines.svh.
`include "positional_list_store_defines.svh"

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic [pls_pkg::PosW-1:0]          position_i,
  input  logic signed [pls_pkg::DataW-1:0]  value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [pls_pkg::DataW-1:0]  item_value_o,
  output logic [pls_pkg::CountW-1:0]        count_o
);
  import pls_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  logic                    accept;
  pls_op_t                 op;
  logic [IW-1:0]           pos;
  logic signed [DataW-1:0] data [CAPACITY];
  logic signed [DataW-1:0] taps [CAPACITY];
  logic signed [DataW-1:0] removed;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pls_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .removed_i    (removed),
    .op_o         (op),
    .pos_o        (pos),
    .done_o       (done_o),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .count_o      (count_o)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = data[g+1];
    end

    pls_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .pos_i   (pos),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[g]),
      .tap_o   (taps[g])
    );
  end

  // at most one cell taps, so an or over the row picks the removed value
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | taps[i];
    end
  end

  `PLS_ASSERT_NXT(a_result_follows, accept, done_o, "item taken without a result next cycle")
  `PLS_ASSERT_IMP(a_error_zero, done_o && (status_o != ST_OK), item_value_o == '0, "error result carries a value")
  `PLS_ASSERT_IMP(a_full_count, done_o && (status_o == ST_FULL), count_o == CountW'(CAPACITY), "full status with count below capacity")
  `PLS_ASSERT_IMP(a_empty_count, done_o && (status_o == ST_EMPTY), count_o == '0, "empty status with nonzero count")

endmodule
